FILE: hdl/mbrr_pkg.sv
// Shared types, constants and the CRC16 byte step for the Modbus read-register master.
`timescale 1ns / 1ps

package mbrr_pkg;

    // input modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_REQ     = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_CRC_ERR = 2'd2;
    localparam logic [1:0] KIND_BAD     = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SLAVE   = 2'd0;
    localparam logic [1:0] CFG_REG     = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;
    localparam logic [1:0] CFG_SILENCE = 2'd3;

    localparam logic [7:0]  RST_SLAVE   = 8'd1;
    localparam logic [15:0] RST_REG     = 16'd4;
    localparam logic [15:0] RST_TIMEOUT = 16'd200;
    localparam logic [7:0]  RST_SILENCE = 8'd4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] REPLY_BYTE_COUNT  = 8'h02;
    localparam logic [7:0] REG_COUNT_HI      = 8'h00;
    localparam logic [7:0] REG_COUNT_LO      = 8'h01;

    typedef struct packed {
        logic [7:0]  slave;
        logic [15:0] timeout;
        logic [7:0]  silence;
    } t_cfg;

    typedef struct packed {
        logic        fire;
        logic [1:0]  kind;
        logic [15:0] level;
        logic [15:0] crc_computed;
        logic [15:0] crc_in_frame;
        logic [4:0]  received_count;
    } t_verdict;

    // one byte of CRC16, reflected polynomial
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/mbrr_in_if.sv
// Input channel: valid/ready handshake with mode and received byte.
`timescale 1ns / 1ps

interface mbrr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

FILE: hdl/mbrr_out_if.sv
// Result channel: valid/ready handshake with request bytes and verdicts.
`timescale 1ns / 1ps

interface mbrr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic signed [15:0] level;
    logic [15:0] crc_computed;
    logic [15:0] crc_in_frame;
    logic [4:0]  received_count;
    logic [31:0] good_count;
    logic [31:0] crc_error_count;
    logic [31:0] bad_count;
    logic        last;

    modport source (output valid, output kind, output tx_byte, output level,
                    output crc_computed, output crc_in_frame, output received_count,
                    output good_count, output crc_error_count, output bad_count,
                    output last, input ready);
    modport sink   (input valid, input kind, input tx_byte, input level,
                    input crc_computed, input crc_in_frame, input received_count,
                    input good_count, input crc_error_count, input bad_count,
                    input last, output ready);
endinterface

FILE: hdl/mbrr_reply.sv
// Reply window tracker: counts reply bytes, checks header and CRC, closes on ticks.
`timescale 1ns / 1ps

module mbrr_reply
    import mbrr_pkg::*;
#(
    parameter int FRAME_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output t_verdict   o_verdict
);

    localparam int CNT_W = $clog2(FRAME_BYTES + 1);
    localparam int EXT_W = (CNT_W > 5) ? CNT_W : 5;

    localparam logic PH_IDLE   = 1'b0;
    localparam logic PH_LISTEN = 1'b1;

    logic             r_phase,     n_phase;
    logic [15:0]      r_elapsed,   n_elapsed;
    logic [7:0]       r_idle,      n_idle;
    logic [CNT_W-1:0] r_count,     n_count;
    logic [15:0]      r_crc,       n_crc;
    logic             r_hdr_ok,    n_hdr_ok;
    logic [15:0]      r_value,     n_value;
    logic [15:0]      r_frame_crc, n_frame_crc;

    logic [EXT_W-1:0] cnt_ext;
    logic [4:0]       cnt_clip;
    logic             close;

    assign cnt_ext  = EXT_W'(r_count);
    assign cnt_clip = (cnt_ext > EXT_W'(31)) ? 5'd31 : cnt_ext[4:0];

    always_comb begin
        n_phase     = r_phase;
        n_elapsed   = r_elapsed;
        n_idle      = r_idle;
        n_count     = r_count;
        n_crc       = r_crc;
        n_hdr_ok    = r_hdr_ok;
        n_value     = r_value;
        n_frame_crc = r_frame_crc;
        close       = 1'b0;

        if (i_accept) begin
            if (i_mode == MODE_START) begin
                n_phase     = PH_LISTEN;
                n_elapsed   = '0;
                n_idle      = '0;
                n_count     = '0;
                n_crc       = CRC_INIT;
                n_hdr_ok    = 1'b0;
                n_value     = '0;
                n_frame_crc = '0;
            end else if (r_phase == PH_LISTEN && i_mode == MODE_BYTE) begin
                if (r_count < CNT_W'(FRAME_BYTES)) begin
                    if (r_count < CNT_W'(5)) begin
                        n_crc = crc_step(r_crc, i_rx_byte);
                    end
                    if (r_count == CNT_W'(0)) begin
                        n_hdr_ok = (i_rx_byte == i_cfg.slave);
                    end else if (r_count == CNT_W'(1)) begin
                        n_hdr_ok = r_hdr_ok && (i_rx_byte == FUNC_READ_HOLDING);
                    end else if (r_count == CNT_W'(2)) begin
                        n_hdr_ok = r_hdr_ok && (i_rx_byte == REPLY_BYTE_COUNT);
                    end else if (r_count == CNT_W'(3)) begin
                        n_value = {i_rx_byte, r_value[7:0]};
                    end else if (r_count == CNT_W'(4)) begin
                        n_value = {r_value[15:8], i_rx_byte};
                    end else if (r_count == CNT_W'(5)) begin
                        n_frame_crc = {r_frame_crc[15:8], i_rx_byte};
                    end else if (r_count == CNT_W'(6)) begin
                        n_frame_crc = {i_rx_byte, r_frame_crc[7:0]};
                    end
                    n_count = r_count + CNT_W'(1);
                end
                // any byte restarts the silence timer
                n_idle = '0;
            end else if (r_phase == PH_LISTEN && i_mode == MODE_TICK) begin
                if (r_elapsed != 16'hFFFF) begin
                    n_elapsed = r_elapsed + 16'd1;
                end
                if (r_count != '0) begin
                    if (r_idle != 8'hFF) begin
                        n_idle = r_idle + 8'd1;
                    end
                    if (n_idle >= i_cfg.silence) begin
                        close = 1'b1;
                    end
                end
                if (n_elapsed >= i_cfg.timeout) begin
                    close = 1'b1;
                end
                if (close) begin
                    n_phase = PH_IDLE;
                end
            end
        end
    end

    always_comb begin
        o_verdict.fire           = close;
        o_verdict.level          = '0;
        o_verdict.crc_computed   = r_crc;
        o_verdict.crc_in_frame   = r_frame_crc;
        o_verdict.received_count = cnt_clip;
        if (r_count == CNT_W'(7) && r_hdr_ok) begin
            if (r_crc == r_frame_crc) begin
                o_verdict.kind  = KIND_GOOD;
                o_verdict.level = r_value;
            end else begin
                o_verdict.kind = KIND_CRC_ERR;
            end
        end else begin
            o_verdict.kind = KIND_BAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_elapsed   <= '0;
            r_idle      <= '0;
            r_count     <= '0;
            r_crc       <= CRC_INIT;
            r_hdr_ok    <= 1'b0;
            r_value     <= '0;
            r_frame_crc <= '0;
        end else begin
            r_phase     <= n_phase;
            r_elapsed   <= n_elapsed;
            r_idle      <= n_idle;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_hdr_ok    <= n_hdr_ok;
            r_value     <= n_value;
            r_frame_crc <= n_frame_crc;
        end
    end

endmodule

FILE: hdl/modbus_rtu_read_register_master.sv
// Top level: Modbus RTU master that polls one holding register.
// Usage:
//   i_in carries one transaction per item: mode 0 starts a poll, mode 1 hands in a
//   byte received from the bus, mode 2 marks one elapsed millisecond.
//   o_out carries results: for a start, eight request bytes (kind 0) in bus order,
//   the last one flagged; for a closed reply window, one verdict (good reading,
//   CRC error, or no/bad response) with the running totals.
//   Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
// Timing:
//   Byte and tick transactions are taken one per cycle while i_in.ready is high; a closing tick shows its
//   verdict in the output register in the cycle after acceptance.
//   A start transaction yields its first request byte the next cycle and then
//   one byte per cycle while o_out.ready is high; i_in.ready stays low while the
//   request sequencer loads the remaining bytes.
//   The request CRC is folded one byte per cycle as the bytes go out, pausing while the output stalls.
// Reset: idle, no window open, totals zero, registers at their default values.
// Stall: while o_out.ready is low the output register holds its transaction and
//   i_in.ready drops; no result is dropped or repeated.
`timescale 1ns / 1ps

module modbus_rtu_read_register_master
    import mbrr_pkg::*;
#(
    parameter int FRAME_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    mbrr_in_if.sink     i_in,
    mbrr_out_if.source  o_out
);

    localparam logic [2:0] LAST_IDX = 3'd7;
    localparam logic [2:0] CRC_LO_IDX = 3'd6;

    // configuration registers
    logic [7:0]  r_slave;
    logic [15:0] r_reg_addr;
    logic [15:0] r_timeout;
    logic [7:0]  r_silence;
    t_cfg        cfg;

    // request sequencer
    logic        r_sending;
    logic [2:0]  r_send_idx;
    logic [15:0] r_tx_crc;
    logic [7:0]  seq_byte;

    // totals
    logic [31:0] r_good, n_good;
    logic [31:0] r_crc_err, n_crc_err;
    logic [31:0] r_bad, n_bad;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [7:0]  r_out_tx;
    logic [15:0] r_out_level;
    logic [15:0] r_out_crc_c;
    logic [15:0] r_out_crc_f;
    logic [4:0]  r_out_cnt;
    logic        r_out_last;

    logic        out_load;
    logic        accept;
    logic        start;
    t_verdict    verdict;

    assign cfg.slave   = r_slave;
    assign cfg.timeout = r_timeout;
    assign cfg.silence = r_silence;

    assign out_load   = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_sending && out_load;
    assign accept     = i_in.valid && i_in.ready;
    assign start      = accept && (i_in.mode == MODE_START);

    mbrr_reply #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_reply (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_mode   (i_in.mode),
        .i_rx_byte(i_in.rx_byte),
        .i_cfg    (cfg),
        .o_verdict(verdict)
    );

    always_comb begin
        case (r_send_idx)
            3'd0:    seq_byte = r_slave;
            3'd1:    seq_byte = FUNC_READ_HOLDING;
            3'd2:    seq_byte = r_reg_addr[15:8];
            3'd3:    seq_byte = r_reg_addr[7:0];
            3'd4:    seq_byte = REG_COUNT_HI;
            3'd5:    seq_byte = REG_COUNT_LO;
            3'd6:    seq_byte = r_tx_crc[7:0];
            default: seq_byte = r_tx_crc[15:8];
        endcase
    end

    always_comb begin
        n_good    = r_good;
        n_crc_err = r_crc_err;
        n_bad     = r_bad;
        if (verdict.fire) begin
            case (verdict.kind)
                KIND_GOOD:    n_good    = r_good + 32'd1;
                KIND_CRC_ERR: n_crc_err = r_crc_err + 32'd1;
                default:      n_bad     = r_bad + 32'd1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave    <= RST_SLAVE;
            r_reg_addr <= RST_REG;
            r_timeout  <= RST_TIMEOUT;
            r_silence  <= RST_SILENCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SLAVE:   r_slave    <= i_cfg_data[7:0];
                CFG_REG:     r_reg_addr <= i_cfg_data;
                CFG_TIMEOUT: r_timeout  <= i_cfg_data;
                CFG_SILENCE: r_silence  <= i_cfg_data[7:0];
                default:     r_slave    <= r_slave;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending   <= 1'b0;
            r_send_idx  <= '0;
            r_tx_crc    <= CRC_INIT;
            r_good      <= '0;
            r_crc_err   <= '0;
            r_bad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_good    <= n_good;
            r_crc_err <= n_crc_err;
            r_bad     <= n_bad;
            if (start) begin
                // emit the slave address now, sequence the rest
                r_sending   <= 1'b1;
                r_send_idx  <= 3'd1;
                r_tx_crc    <= crc_step(CRC_INIT, r_slave);
                r_out_valid <= 1'b1;
            end else if (r_sending && out_load) begin
                if (r_send_idx < CRC_LO_IDX) begin
                    r_tx_crc <= crc_step(r_tx_crc, seq_byte);
                end
                if (r_send_idx == LAST_IDX) begin
                    r_sending <= 1'b0;
                end
                r_send_idx  <= r_send_idx + 3'd1;
                r_out_valid <= 1'b1;
            end else if (verdict.fire) begin
                r_out_valid <= 1'b1;
            end else if (out_load) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the output register
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_out_kind  <= KIND_REQ;
            r_out_tx    <= r_slave;
            r_out_level <= '0;
            r_out_crc_c <= '0;
            r_out_crc_f <= '0;
            r_out_cnt   <= '0;
            r_out_last  <= 1'b0;
        end else if (r_sending && out_load) begin
            r_out_kind  <= KIND_REQ;
            r_out_tx    <= seq_byte;
            r_out_level <= '0;
            r_out_crc_c <= '0;
            r_out_crc_f <= '0;
            r_out_cnt   <= '0;
            r_out_last  <= (r_send_idx == LAST_IDX);
        end else if (verdict.fire) begin
            r_out_kind  <= verdict.kind;
            r_out_tx    <= '0;
            r_out_level <= verdict.level;
            r_out_crc_c <= verdict.crc_computed;
            r_out_crc_f <= verdict.crc_in_frame;
            r_out_cnt   <= verdict.received_count;
            r_out_last  <= 1'b1;
        end
    end

    // totals follow the live counters, so a held transaction keeps its values
    // only if they were captured; capture them alongside the payload
    logic [31:0] r_out_good;
    logic [31:0] r_out_crc_err;
    logic [31:0] r_out_bad;

    always_ff @(posedge i_clk) begin
        if (start || (r_sending && out_load) || verdict.fire) begin
            r_out_good    <= n_good;
            r_out_crc_err <= n_crc_err;
            r_out_bad     <= n_bad;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.kind            = r_out_kind;
    assign o_out.tx_byte         = r_out_tx;
    assign o_out.level           = r_out_level;
    assign o_out.crc_computed    = r_out_crc_c;
    assign o_out.crc_in_frame    = r_out_crc_f;
    assign o_out.received_count  = r_out_cnt;
    assign o_out.good_count      = r_out_good;
    assign o_out.crc_error_count = r_out_crc_err;
    assign o_out.bad_count       = r_out_bad;
    assign o_out.last            = r_out_last;

endmodule

FILE: tb/tb_modbus_rtu_read_register_master.sv
// Testbench for the Modbus RTU read-register master: predicted request bytes and verdicts.
`timescale 1ns / 1ps

module tb_modbus_rtu_read_register_master;
    import mbrr_pkg::*;

    localparam int          FRAME_BYTES   = 16;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam logic [1:0]  MODE_UNUSED   = 2'd3;

    typedef enum logic { WIN_IDLE, WIN_OPEN } t_window;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [15:0] level;
        logic [15:0] crc_computed;
        logic [15:0] crc_in_frame;
        logic [4:0]  received_count;
        logic [31:0] good_count;
        logic [31:0] crc_error_count;
        logic [31:0] bad_count;
        logic        last;
    } t_poll_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    mbrr_in_if  in_if ();
    mbrr_out_if out_if ();

    modbus_rtu_read_register_master #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // predictor copy of the registers and the poll state
    logic [7:0]  cfg_slave;
    logic [15:0] cfg_reg_addr;
    logic [15:0] cfg_timeout;
    logic [7:0]  cfg_silence;
    t_window     window;
    logic [15:0] elapsed_ms;
    logic [7:0]  quiet_ms;
    int unsigned rcv_count;
    logic [15:0] reply_crc;
    logic        header_ok;
    logic [15:0] reading;
    logic [15:0] crc_rx;
    logic [31:0] good_total;
    logic [31:0] crc_fail_total;
    logic [31:0] bad_total;

    t_poll_result due_results[$];
    t_poll_result due_head;
    logic [7:0]   reply_bytes [0:19];

    int unsigned  mismatches;
    int unsigned  results_checked;
    int unsigned  items_taken;
    int unsigned  cycles;
    int unsigned  stall_left;
    bit           gaps_on;
    bit           stalls_on;
    bit           in_valid_high;

    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc,
                                                       input logic [7:0] data);
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        repeat (8) begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    task automatic push_result(input logic [1:0] kind, input logic [7:0] tx,
                               input logic [15:0] level, input logic last);
        t_poll_result r;
        r.kind            = kind;
        r.tx_byte         = tx;
        r.level           = level;
        r.crc_computed    = (kind == KIND_REQ) ? 16'h0000 : reply_crc;
        r.crc_in_frame    = (kind == KIND_REQ) ? 16'h0000 : crc_rx;
        r.received_count  = (kind == KIND_REQ) ? 5'd0 :
                            (rcv_count > 31) ? 5'd31 : 5'(rcv_count);
        r.good_count      = good_total;
        r.crc_error_count = crc_fail_total;
        r.bad_count       = bad_total;
        r.last            = last;
        due_results.push_back(r);
    endtask

    task automatic reset_poll_model();
        cfg_slave      = RST_SLAVE;
        cfg_reg_addr   = RST_REG;
        cfg_timeout    = RST_TIMEOUT;
        cfg_silence    = RST_SILENCE;
        window         = WIN_IDLE;
        elapsed_ms     = '0;
        quiet_ms       = '0;
        rcv_count      = 0;
        reply_crc      = CRC_INIT;
        header_ok      = 1'b0;
        reading        = '0;
        crc_rx         = '0;
        good_total     = '0;
        crc_fail_total = '0;
        bad_total      = '0;
    endtask

    task automatic predict_poll_results(input logic [1:0] mode, input logic [7:0] data);
        logic [7:0]  req [0:7];
        logic [15:0] crc;
        logic        closing;
        case (mode)
            MODE_START: begin
                req[0] = cfg_slave;
                req[1] = FUNC_READ_HOLDING;
                req[2] = cfg_reg_addr[15:8];
                req[3] = cfg_reg_addr[7:0];
                req[4] = REG_COUNT_HI;
                req[5] = REG_COUNT_LO;
                crc = CRC_INIT;
                for (int k = 0; k < 6; k++) crc = crc16_modbus_byte(crc, req[k]);
                req[6] = crc[7:0];
                req[7] = crc[15:8];
                for (int k = 0; k < 8; k++) push_result(KIND_REQ, req[k], 16'h0000, k == 7);
                // drop any open window and start listening afresh
                window     = WIN_OPEN;
                elapsed_ms = '0;
                quiet_ms   = '0;
                rcv_count  = 0;
                reply_crc  = CRC_INIT;
                header_ok  = 1'b0;
                reading    = '0;
                crc_rx     = '0;
            end
            MODE_BYTE: begin
                if (window == WIN_OPEN) begin
                    if (rcv_count < FRAME_BYTES) begin
                        if (rcv_count < 5) reply_crc = crc16_modbus_byte(reply_crc, data);
                        case (rcv_count)
                            0: header_ok = (data == cfg_slave);
                            1: header_ok = header_ok && (data == FUNC_READ_HOLDING);
                            2: header_ok = header_ok && (data == REPLY_BYTE_COUNT);
                            3: reading[15:8] = data;
                            4: reading[7:0]  = data;
                            5: crc_rx[7:0]   = data;
                            6: crc_rx[15:8]  = data;
                            default: ;
                        endcase
                        rcv_count++;
                    end
                    // extra bytes still restart the silence timer
                    quiet_ms = '0;
                end
            end
            MODE_TICK: begin
                if (window == WIN_OPEN) begin
                    closing = 1'b0;
                    if (elapsed_ms != 16'hFFFF) elapsed_ms++;
                    if (rcv_count > 0) begin
                        if (quiet_ms != 8'hFF) quiet_ms++;
                        if (quiet_ms >= cfg_silence) closing = 1'b1;
                    end
                    if (elapsed_ms >= cfg_timeout) closing = 1'b1;
                    if (closing) begin
                        window = WIN_IDLE;
                        if (rcv_count == 7 && header_ok) begin
                            if (reply_crc == crc_rx) begin
                                good_total++;
                                push_result(KIND_GOOD, 8'h00, reading, 1'b1);
                            end else begin
                                crc_fail_total++;
                                push_result(KIND_CRC_ERR, 8'h00, 16'h0000, 1'b1);
                            end
                        end else begin
                            bad_total++;
                            push_result(KIND_BAD, 8'h00, 16'h0000, 1'b1);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [1:0] mode, input logic [7:0] data);
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            if (in_valid_high) in_if.valid <= 1'b0;
            in_valid_high = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.mode    <= mode;
        in_if.rx_byte <= data;
        in_valid_high = 1'b1;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (mode == MODE_START ||
            (window == WIN_OPEN && (mode == MODE_BYTE || mode == MODE_TICK)))
            items_taken++;
        predict_poll_results(mode, data);
    endtask

    // drop valid, wait for every due result, then let in-flight items finish
    task automatic settle();
        if (in_valid_high) in_if.valid <= 1'b0;
        in_valid_high = 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic close_window();
        while (window == WIN_OPEN) begin
            if (rcv_count == 0 && cfg_timeout > 64) send_item(MODE_BYTE, 8'($urandom));
            else send_item(MODE_TICK, 8'($urandom));
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SLAVE:   cfg_slave    = data[7:0];
            CFG_REG:     cfg_reg_addr = data;
            CFG_TIMEOUT: cfg_timeout  = data;
            CFG_SILENCE: cfg_silence  = data[7:0];
            default: ;
        endcase
    endtask

    task automatic program_config(input logic [7:0] slave, input logic [15:0] reg_addr,
                                  input logic [15:0] timeout, input logic [7:0] silence);
        logic [7:0] junk_hi;
        logic [7:0] junk_lo;
        close_window();
        settle();
        junk_hi = 8'($urandom);
        junk_lo = 8'($urandom);
        // upper bits of the narrow registers must be ignored
        write_reg(CFG_SLAVE, {junk_hi, slave});
        write_reg(CFG_REG, reg_addr);
        write_reg(CFG_TIMEOUT, timeout);
        write_reg(CFG_SILENCE, {junk_lo, silence});
        i_cfg_we <= 1'b0;
    endtask

    task automatic fill_reply(input logic [15:0] value);
        logic [15:0] crc;
        reply_bytes[0] = cfg_slave;
        reply_bytes[1] = FUNC_READ_HOLDING;
        reply_bytes[2] = REPLY_BYTE_COUNT;
        reply_bytes[3] = value[15:8];
        reply_bytes[4] = value[7:0];
        crc = CRC_INIT;
        for (int k = 0; k < 5; k++) crc = crc16_modbus_byte(crc, reply_bytes[k]);
        reply_bytes[5] = crc[7:0];
        reply_bytes[6] = crc[15:8];
        for (int k = 7; k < 20; k++) reply_bytes[k] = 8'($urandom);
    endtask

    task automatic send_reply_bytes(input int unsigned len, input bit interleave);
        for (int k = 0; k < len; k++) begin
            if (interleave && $urandom_range(0, 7) == 0)
                send_item($urandom_range(0, 1) ? MODE_TICK : MODE_UNUSED, 8'($urandom));
            send_item(MODE_BYTE, reply_bytes[k]);
        end
    endtask

    task automatic test_defaults_and_idle_noise();
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_TICK, 8'h00);
        send_item(MODE_UNUSED, 8'hA5);
        send_item(MODE_START, 8'h00);
        fill_reply(16'h8000);
        send_reply_bytes(7, 1'b0);
        close_window();
        send_item(MODE_START, 8'hFF);
        fill_reply(16'h7FFF);
        reply_bytes[6] = reply_bytes[6] ^ 8'h80;
        send_reply_bytes(7, 1'b0);
        close_window();
    endtask

    task automatic test_zero_windows_and_restart();
        program_config(8'h00, 16'hFFFF, 16'd0, 8'd0);
        send_item(MODE_START, 8'h00);
        send_item(MODE_TICK, 8'h00);
        send_item(MODE_START, 8'h00);
        send_item(MODE_BYTE, 8'h00);
        // restart while listening: the partial reply is dropped without a verdict
        send_item(MODE_START, 8'h00);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_TICK, 8'h00);
        // silence and timeout expire on the same tick
        program_config(8'hFF, 16'h0000, 16'd3, 8'd3);
        send_item(MODE_START, 8'h00);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_TICK, 8'h00);
        send_item(MODE_TICK, 8'h00);
        send_item(MODE_TICK, 8'h00);
    endtask

    task automatic run_random_polls(input int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        stop_at = items_taken + budget;
        while (items_taken < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                case ($urandom_range(0, 2))
                    0: send_item(MODE_BYTE, 8'($urandom));
                    1: send_item(MODE_TICK, 8'($urandom));
                    default: send_item(MODE_UNUSED, 8'($urandom));
                endcase
                continue;
            end
            send_item(MODE_START, 8'($urandom));
            fill_reply(16'($urandom));
            len = 7;
            if (pick < 50) begin
                // well-formed reply
            end else if (pick < 64) begin
                reply_bytes[$urandom_range(5, 6)] ^= 8'(1 << $urandom_range(0, 7));
            end else if (pick < 74) begin
                reply_bytes[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
            end else if (pick < 84) begin
                len = $urandom_range(0, 20);
                for (int k = 0; k < 20; k++) reply_bytes[k] = 8'($urandom);
            end else if (pick < 92) begin
                len = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(8, 18);
            end else begin
                // leave the window open; the next start or tick deals with it
                send_reply_bytes($urandom_range(0, 6), 1'b1);
                continue;
            end
            send_reply_bytes(len, 1'b1);
            close_window();
        end
        close_window();
    endtask

    task automatic test_random_extremes();
        program_config(8'h00, 16'h0000, 16'hFFFF, 8'd1);
        run_random_polls(40);
        program_config(8'hFF, 16'hFFFF, 16'd1, 8'd255);
        run_random_polls(30);
        program_config(8'($urandom), 16'($urandom), 16'($urandom_range(2, 40)),
                       8'($urandom_range(1, 8)));
        run_random_polls(60);
        // long silence against a timeout that never fires
        program_config(8'($urandom), 16'($urandom), 16'hFFFF, 8'd255);
        run_random_polls(20);
    endtask

    task automatic test_back_to_back();
        program_config(8'($urandom), 16'($urandom), 16'($urandom_range(8, 60)),
                       8'($urandom_range(1, 6)));
        settle();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_random_polls(50);
    endtask

    // result checker
    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d tx 0x%0h",
                         $time, out_if.kind, out_if.tx_byte);
                mismatches++;
            end else begin
                due_head = due_results.pop_front();
                results_checked++;
                check_field("kind", due_head.kind, out_if.kind);
                check_field("tx_byte", due_head.tx_byte, out_if.tx_byte);
                check_field("level", due_head.level, $unsigned(out_if.level));
                check_field("crc_computed", due_head.crc_computed, out_if.crc_computed);
                check_field("crc_in_frame", due_head.crc_in_frame, out_if.crc_in_frame);
                check_field("received_count", due_head.received_count, out_if.received_count);
                check_field("good_count", due_head.good_count, out_if.good_count);
                check_field("crc_error_count", due_head.crc_error_count, out_if.crc_error_count);
                check_field("bad_count", due_head.bad_count, out_if.bad_count);
                check_field("last", due_head.last, out_if.last);
            end
        end
    end

    // result-side backpressure in random bursts
    always @(posedge i_clk) begin
        if (!stalls_on) begin
            out_if.ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left   <= $urandom_range(0, 10);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: run timed out with %0d results outstanding", $time, due_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_SLAVE;
        i_cfg_data     = '0;
        in_if.valid    = 1'b0;
        in_if.mode     = MODE_TICK;
        in_if.rx_byte  = '0;
        out_if.ready   = 1'b0;
        mismatches     = 0;
        results_checked = 0;
        items_taken    = 0;
        cycles         = 0;
        stall_left     = 0;
        gaps_on        = 1'b1;
        stalls_on      = 1'b1;
        in_valid_high  = 1'b0;
        reset_poll_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults_and_idle_noise();
        test_zero_windows_and_restart();
        test_random_extremes();
        test_back_to_back();
        close_window();
        settle();

        $display("Covered %0d accepted items and %0d checked results across eight register setups",
                 items_taken, results_checked);
        $display("Verdicts seen: %0d good readings, %0d CRC errors, %0d bad or missing replies",
                 good_total, crc_fail_total, bad_total);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
